>>> rtl/lgf_pkg.sv
package lgf_pkg;

   // number of orbitals held in the self-energy table
   localparam int ORBITALS = 4;
   localparam int ORB_W    = (ORBITALS > 1) ? $clog2(ORBITALS) : 1;

   // quarter-wave cosine polynomial coefficients, Q30
   localparam logic [30:0] COS_A = 31'd1324675879;
   localparam logic [30:0] COS_B = 31'd272375560;
   localparam logic [30:0] COS_C = 31'd22401992;
   localparam logic [30:0] COS_D = 31'd987047;

   // input command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_HOP_T  = 3'd0;
   localparam logic [2:0] REG_HOP_T1 = 3'd1;
   localparam logic [2:0] REG_FIELD  = 3'd2;
   localparam logic [2:0] REG_CHEM   = 3'd3;
   localparam logic [2:0] REG_FRE    = 3'd4;
   localparam logic [2:0] REG_FIM    = 3'd5;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_SQ, OP_X2D, OP_PC, OP_PB, OP_PA, OP_COS,
      OP_CXY, OP_T1, OP_T2, OP_BASE, OP_AB, OP_SQA, OP_SQB, OP_DEN,
      OP_CHK, OP_DIV, OP_PACK
   } lgf_op_type;

   typedef struct packed {
      lgf_op_type       op;
      logic             sel_y;
      logic [ORB_W-1:0] orb;
   } lgf_cmd_type;

   typedef struct packed {
      logic den_zero;
   } lgf_stat_type;

   typedef struct packed {
      logic [31:0] hop_t;
      logic [31:0] hop_t1;
      logic [31:0] field_shift;
      logic [31:0] chem_potential;
      logic [31:0] freq_re;
      logic [31:0] freq_im;
   } lgf_cfg_type;

endpackage

>>> rtl/lgf_csr.sv
module lgf_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output lgf_pkg::lgf_cfg_type cfg
);
   import lgf_pkg::*;

   lgf_cfg_type cfg_ff;
   logic        wr_en;
   logic [2:0]  idx;

   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_HOP_T:  cfg_ff.hop_t          <= csr_pwdata;
            REG_HOP_T1: cfg_ff.hop_t1         <= csr_pwdata;
            REG_FIELD:  cfg_ff.field_shift    <= csr_pwdata;
            REG_CHEM:   cfg_ff.chem_potential <= csr_pwdata;
            REG_FRE:    cfg_ff.freq_re        <= csr_pwdata;
            REG_FIM:    cfg_ff.freq_im        <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_HOP_T:  csr_prdata = cfg_ff.hop_t;
         REG_HOP_T1: csr_prdata = cfg_ff.hop_t1;
         REG_FIELD:  csr_prdata = cfg_ff.field_shift;
         REG_CHEM:   csr_prdata = cfg_ff.chem_potential;
         REG_FRE:    csr_prdata = cfg_ff.freq_re;
         REG_FIM:    csr_prdata = cfg_ff.freq_im;
         default:    csr_prdata = '0;
      endcase
   end

endmodule

>>> rtl/lgf_ctrl.sv
module lgf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_command,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  lgf_pkg::lgf_stat_type stat,
   output lgf_pkg::lgf_cmd_type  cmd
);
   import lgf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ, ST_X2D, ST_PC, ST_PB, ST_PA, ST_COS, ST_CXY, ST_T1,
      ST_T2, ST_BASE, ST_AB, ST_SQA, ST_SQB, ST_DEN, ST_CHK, ST_DIV, ST_PACK
   } state_type;

   state_type        state_ff;
   logic             sel_y_ff;
   logic [ORB_W-1:0] orb_ff;
   logic [5:0]       cnt_ff;
   logic             rsp_valid_ff;
   logic             out_free;
   logic             orb_last;
   lgf_op_type       op;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign orb_last   = (orb_ff == ORB_W'(ORBITALS - 1));
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd        = '{op: op, sel_y: sel_y_ff, orb: orb_ff};

   // operation issued to the datapath
   always_comb begin
      case (state_ff)
         ST_IDLE: op = req_tvalid ? OP_LOAD : OP_NOP;
         ST_SQ:   op = OP_SQ;
         ST_X2D:  op = OP_X2D;
         ST_PC:   op = OP_PC;
         ST_PB:   op = OP_PB;
         ST_PA:   op = OP_PA;
         ST_COS:  op = OP_COS;
         ST_CXY:  op = OP_CXY;
         ST_T1:   op = OP_T1;
         ST_T2:   op = OP_T2;
         ST_BASE: op = OP_BASE;
         ST_AB:   op = OP_AB;
         ST_SQA:  op = OP_SQA;
         ST_SQB:  op = OP_SQB;
         ST_DEN:  op = OP_DEN;
         ST_CHK:  op = OP_CHK;
         ST_DIV:  op = OP_DIV;
         ST_PACK: op = out_free ? OP_PACK : OP_NOP;
         default: op = OP_NOP;
      endcase
   end

   // sequencer state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_y_ff     <= 1'b0;
         orb_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_PACK && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_command == CMD_EVAL) begin
                  sel_y_ff <= 1'b0;
                  orb_ff   <= '0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ:   state_ff <= ST_X2D;
            ST_X2D:  state_ff <= ST_PC;
            ST_PC:   state_ff <= ST_PB;
            ST_PB:   state_ff <= ST_PA;
            ST_PA:   state_ff <= ST_COS;
            ST_COS: begin
               if (!sel_y_ff) begin
                  sel_y_ff <= 1'b1;
                  state_ff <= ST_SQ;
               end else begin
                  state_ff <= ST_CXY;
               end
            end
            ST_CXY:  state_ff <= ST_T1;
            ST_T1:   state_ff <= ST_T2;
            ST_T2:   state_ff <= ST_BASE;
            ST_BASE: state_ff <= ST_AB;
            ST_AB:   state_ff <= ST_SQA;
            ST_SQA:  state_ff <= ST_SQB;
            ST_SQB:  state_ff <= ST_DEN;
            ST_DEN:  state_ff <= ST_CHK;
            ST_CHK: begin
               cnt_ff   <= '0;
               state_ff <= stat.den_zero ? ST_PACK : ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd32) begin
                  state_ff <= ST_PACK;
               end
            end
            ST_PACK: begin
               if (out_free) begin
                  if (orb_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     orb_ff   <= orb_ff + ORB_W'(1);
                     state_ff <= ST_AB;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_pack_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_PACK |=> rsp_valid_ff)
      else $error("result not marked valid after pack");
   a_pack_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_PACK |-> (!rsp_valid_ff || rsp_tready))
      else $error("pack over an untaken result");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= 6'd32)
      else $error("divider iteration count overrun");
   a_orb_range: assert property (@(posedge clock) disable iff (reset)
      32'(orb_ff) < ORBITALS)
      else $error("orbital index out of range");
`endif

endmodule

>>> rtl/lgf_dpath.sv
module lgf_dpath (
   input  logic                  clock,
   input  lgf_pkg::lgf_cmd_type  cmd,
   output lgf_pkg::lgf_stat_type stat,
   input  lgf_pkg::lgf_cfg_type  cfg,
   input  logic                  in_command,
   input  logic [15:0]           in_kx,
   input  logic [15:0]           in_ky,
   input  logic [3:0]            in_slot,
   input  logic [31:0]           in_self_re,
   input  logic [31:0]           in_self_im,
   output logic [3:0]            out_orbital,
   output logic [31:0]           out_green_re,
   output logic [31:0]           out_green_im,
   output logic                  out_saturated,
   output logic                  out_last
);
   import lgf_pkg::*;

   logic [63:0]        se_tab_ff [ORBITALS];
   logic [15:0]        kx_ff, ky_ff;
   logic signed [65:0] prod_ff;
   logic [30:0]        x2_ff;
   logic signed [15:0] cx_ff, cy_ff;
   logic signed [30:0] cxcy_ff;
   logic signed [37:0] base_ff;
   logic [30:0]        ua_s_ff, ub_s_ff;
   logic [2:0]         shift_ff;
   logic               neg_re_ff, neg_im_ff;
   logic [62:0]        den_ff;
   logic [63:0]        rem_re_ff, rem_im_ff;
   logic [32:0]        q_re_ff, q_im_ff;
   logic               big_re_ff, big_im_ff;
   logic [3:0]         orb_out_ff;
   logic [31:0]        gre_ff, gim_ff;
   logic               sat_ff, last_ff;

   logic [15:0]        phase;
   logic [14:0]        u;
   logic signed [32:0] mul_a, mul_b;
   logic [30:0]        coef;
   logic signed [32:0] h;
   logic [32:0]        t_val;
   logic [30:0]        v_val;
   logic [31:0]        r_sum;
   logic [14:0]        c_mag;
   logic signed [15:0] c_val;
   logic signed [16:0] c_sum;
   logic signed [65:0] rs1, rs2;
   logic signed [37:0] term1, term2;
   logic [63:0]        se_rd;
   logic signed [37:0] a_val;
   logic signed [32:0] b_val;
   logic [37:0]        ua, ub, or_v;
   logic [2:0]         shift_sel;
   logic [63:0]        den64;
   logic [63:0]        rem2_re, rem2_im;
   logic               ge_re, ge_im;
   logic               ov_re, ov_im;
   logic [31:0]        p_re, p_im;

   assign stat.den_zero = (den_ff == 63'd0);

   // cosine argument folding into a quarter turn
   assign phase = cmd.sel_y ? ky_ff : kx_ff;
   assign u = (phase[15:14] == 2'd0 || phase[15:14] == 2'd2) ?
              {1'b0, phase[13:0]} : 15'(15'd16384 - {1'b0, phase[13:0]});

   // polynomial step: coefficient less previous product
   always_comb begin
      case (cmd.op)
         OP_PC:   coef = COS_C;
         OP_PB:   coef = COS_B;
         default: coef = COS_A;
      endcase
   end
   assign h = $signed({2'b00, coef}) - $signed({1'b0, prod_ff[61:30]});

   // finish of the cosine
   assign t_val = prod_ff[62:30];
   assign v_val = (t_val < 33'd1073741824) ? 31'(33'd1073741824 - t_val) : 31'd0;
   assign r_sum = {1'b0, v_val} + 32'd16384;
   assign c_mag = (r_sum[31:15] > 17'd32767) ? 15'd32767 : r_sum[29:15];
   assign c_val = (phase[15:14] == 2'd1 || phase[15:14] == 2'd2) ?
                  -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
   assign c_sum = 17'(cx_ff) + 17'(cy_ff);

   // band terms, rounded half up
   assign rs1   = prod_ff + 66'sd8192;
   assign rs2   = prod_ff + 66'sd134217728;
   assign term1 = rs1[51:14];
   assign term2 = rs2[65:28];

   // denominator parts and common scaling
   assign se_rd = se_tab_ff[cmd.orb];
   assign a_val = base_ff - 38'($signed(se_rd[31:0]));
   assign b_val = 33'($signed(cfg.freq_im)) - 33'($signed(se_rd[63:32]));
   assign ua    = a_val[37] ? 38'(-a_val) : 38'(a_val);
   assign ub    = b_val[32] ? 38'(-b_val) : 38'(b_val);
   assign or_v  = ua | ub;

   always_comb begin
      shift_sel = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if ((or_v >> (31 + i)) == 38'd0) begin
            shift_sel = 3'(i);
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.op)
         OP_SQ: begin
            mul_a = $signed({18'd0, u});
            mul_b = $signed({18'd0, u});
         end
         OP_X2D: begin
            mul_a = $signed({2'b00, prod_ff[28:0], 2'b00});
            mul_b = $signed({2'b00, COS_D});
         end
         OP_PC, OP_PB, OP_PA: begin
            mul_a = $signed({2'b00, x2_ff});
            mul_b = h;
         end
         OP_CXY: begin
            mul_a = 33'(cx_ff);
            mul_b = 33'(cy_ff);
         end
         OP_T1: begin
            mul_a = 33'($signed(cfg.hop_t));
            mul_b = 33'(c_sum);
         end
         OP_T2: begin
            mul_a = 33'($signed(cfg.hop_t1));
            mul_b = 33'(cxcy_ff);
         end
         OP_SQA: begin
            mul_a = $signed({2'b00, ua_s_ff});
            mul_b = $signed({2'b00, ua_s_ff});
         end
         OP_SQB: begin
            mul_a = $signed({2'b00, ub_s_ff});
            mul_b = $signed({2'b00, ub_s_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // restoring divider step, two lanes sharing the denominator
   assign den64   = {1'b0, den_ff};
   assign rem2_re = {rem_re_ff[62:0], 1'b0};
   assign rem2_im = {rem_im_ff[62:0], 1'b0};
   assign ge_re   = rem2_re >= den64;
   assign ge_im   = rem2_im >= den64;

   // saturation to signed 32 bits
   assign ov_re = big_re_ff || (neg_re_ff ? (q_re_ff > 33'h080000000)
                                          : (q_re_ff > 33'h07FFFFFFF));
   assign ov_im = big_im_ff || (neg_im_ff ? (q_im_ff > 33'h080000000)
                                          : (q_im_ff > 33'h07FFFFFFF));
   assign p_re  = neg_re_ff ? (ov_re ? 32'h8000_0000 : 32'(33'd0 - q_re_ff))
                            : (ov_re ? 32'h7FFF_FFFF : q_re_ff[31:0]);
   assign p_im  = neg_im_ff ? (ov_im ? 32'h8000_0000 : 32'(33'd0 - q_im_ff))
                            : (ov_im ? 32'h7FFF_FFFF : q_im_ff[31:0]);

   // self-energy table
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && in_command == CMD_WRITE &&
          {1'b0, in_slot} < 5'(ORBITALS)) begin
         se_tab_ff[in_slot[ORB_W-1:0]] <= {in_self_im, in_self_re};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_LOAD: begin
            if (in_command == CMD_EVAL) begin
               kx_ff <= in_kx;
               ky_ff <= in_ky;
            end
         end
         OP_X2D: x2_ff <= {prod_ff[28:0], 2'b00};
         OP_COS: begin
            if (cmd.sel_y) begin
               cy_ff <= c_val;
            end else begin
               cx_ff <= c_val;
            end
         end
         OP_T1: cxcy_ff <= prod_ff[30:0];
         OP_T2: base_ff <= 38'($signed(cfg.freq_re)) + 38'($signed(cfg.chem_potential))
                         + 38'($signed(cfg.field_shift)) + term1;
         OP_BASE: base_ff <= base_ff + term2;
         OP_AB: begin
            ua_s_ff   <= 31'(ua >> shift_sel);
            ub_s_ff   <= 31'(ub >> shift_sel);
            shift_ff  <= shift_sel;
            neg_re_ff <= a_val[37];
            neg_im_ff <= !b_val[32] && (b_val != 33'sd0);
         end
         OP_SQB: den_ff <= prod_ff[62:0];
         OP_DEN: begin
            den_ff    <= den_ff + prod_ff[62:0];
            rem_re_ff <= {33'd0, ua_s_ff} << (4'd15 - {1'b0, shift_ff});
            rem_im_ff <= {33'd0, ub_s_ff} << (4'd15 - {1'b0, shift_ff});
         end
         OP_CHK: begin
            big_re_ff <= rem_re_ff >= den64;
            big_im_ff <= rem_im_ff >= den64;
            q_re_ff   <= '0;
            q_im_ff   <= '0;
         end
         OP_DIV: begin
            rem_re_ff <= ge_re ? rem2_re - den64 : rem2_re;
            rem_im_ff <= ge_im ? rem2_im - den64 : rem2_im;
            q_re_ff   <= {q_re_ff[31:0], ge_re};
            q_im_ff   <= {q_im_ff[31:0], ge_im};
         end
         OP_PACK: begin
            orb_out_ff <= 4'(cmd.orb);
            last_ff    <= (cmd.orb == ORB_W'(ORBITALS - 1));
            if (stat.den_zero) begin
               gre_ff <= 32'h7FFF_FFFF;
               gim_ff <= 32'd0;
               sat_ff <= 1'b1;
            end else begin
               gre_ff <= p_re;
               gim_ff <= p_im;
               sat_ff <= ov_re | ov_im;
            end
         end
         default: ;
      endcase
   end

   assign out_orbital   = orb_out_ff;
   assign out_green_re  = gre_ff;
   assign out_green_im  = gim_ff;
   assign out_saturated = sat_ff;
   assign out_last      = last_ff;

endmodule

>>> rtl/lattice_green_function_eval_core.sv
// Square-lattice Green value evaluator. An evaluate item (tuser high) carries a
// k-point; the core forms the band energy from the hopping, shift, chemical
// potential and frequency registers and returns one complex Green value per
// orbital, orbitals in ascending order, tlast on the final one, tuser set when
// the value was saturated (zero denominator or clipped quotient). A write item
// (tuser low) loads one self-energy table entry and returns nothing; every
// orbital must be written before the first evaluation. The cosines, the band
// terms and the denominator squares share one 33x33 multiplier, and the
// quotients come from a radix-2 divider, which an orbital with a zero
// denominator skips. The user must write registers through the APB port
// only while no evaluation is in flight; the core does not enforce this.
module lattice_green_function_eval_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kx_phase[15:0], ky_phase[31:16], orbital_slot[35:32], self_re[67:36],
   // self_im[99:68], zero[103:100]
   input  logic [103:0] req_tdata,
   // command[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // orbital_out[3:0], green_re[35:4], green_im[67:36], zero[71:68]
   output logic [71:0]  rsp_tdata,
   // saturated[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import lgf_pkg::*;

   lgf_cfg_type  cfg;
   lgf_cmd_type  cmd;
   lgf_stat_type stat;
   logic [3:0]   orb_out;
   logic [31:0]  gre, gim;

   lgf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lgf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   lgf_dpath u_dpath (
      .clock         (clock),
      .cmd           (cmd),
      .stat          (stat),
      .cfg           (cfg),
      .in_command    (req_tuser),
      .in_kx         (req_tdata[15:0]),
      .in_ky         (req_tdata[31:16]),
      .in_slot       (req_tdata[35:32]),
      .in_self_re    (req_tdata[67:36]),
      .in_self_im    (req_tdata[99:68]),
      .out_orbital   (orb_out),
      .out_green_re  (gre),
      .out_green_im  (gim),
      .out_saturated (rsp_tuser),
      .out_last      (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {4'd0, gim, gre, orb_out};

endmodule
